// ===== hdl/h2fp_pkg.sv =====
// shared types and constants of the http/2 frame parser
package h2fp_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam logic [23:0] MAX_FRAME_RESET = 24'd16384;

    localparam logic [7:0] FT_DATA          = 8'd0;
    localparam logic [7:0] FT_HEADERS       = 8'd1;
    localparam logic [7:0] FT_PRIORITY      = 8'd2;
    localparam logic [7:0] FT_RST_STREAM    = 8'd3;
    localparam logic [7:0] FT_SETTINGS      = 8'd4;
    localparam logic [7:0] FT_PING          = 8'd6;
    localparam logic [7:0] FT_GOAWAY        = 8'd7;
    localparam logic [7:0] FT_WINDOW_UPDATE = 8'd8;
    localparam logic [7:0] FT_CONTINUATION  = 8'd9;

    localparam int FLAG_PADDED_BIT = 3;
    localparam int FLAG_PRIO_BIT   = 5;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_PROTOCOL   = 2'd1;
    localparam logic [1:0] ST_FRAME_SIZE = 2'd2;

    localparam logic [15:0] SET_ENABLE_PUSH    = 16'd2;
    localparam logic [15:0] SET_INITIAL_WINDOW = 16'd4;
    localparam logic [15:0] SET_MAX_FRAME_SIZE = 16'd5;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_ENTRY   = 1'b1;

    typedef struct packed {
        logic        has_entry;
        logic        has_sum;
        logic        oversize;
        logic [1:0]  entry_status;
        logic [31:0] entry_val;
        logic [15:0] entry_id;
        logic [7:0]  ftype;
        logic [7:0]  flags;
        logic [30:0] stream;
        logic [23:0] length;
        logic [7:0]  pad;
        logic [63:0] coll;
        logic [1:0]  fstatus;
        logic        mod6_zero;
    } h2fp_event_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ftype;
        logic [7:0]  flags;
        logic [30:0] stream;
        logic [23:0] length;
        logic [1:0]  status;
        logic [2:0]  offset;
        logic [23:0] clen;
        logic [63:0] v1;
        logic [31:0] v2;
        logic        excl;
        logic        last;
    } h2fp_res_t;

endpackage

// ===== hdl/h2fp_front.sv =====
// byte parser: header collection, payload capture, settings entry checks
module h2fp_front
    import h2fp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    input  logic        q_full,
    output logic        ev_push,
    output h2fp_event_t ev
);

    typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_HALTED} phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hcnt_reg, hcnt_next;
    logic [23:0] len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  flags_reg, flags_next;
    logic [30:0] stream_reg, stream_next;
    logic [23:0] pcnt_reg, pcnt_next;
    logic [2:0]  m6_reg, m6_next;
    logic [7:0]  pad_reg, pad_next;
    logic [63:0] coll_reg, coll_next;
    logic [47:0] entry_reg, entry_next;
    logic [1:0]  fst_reg, fst_next;
    logic [23:0] max_reg;

    logic        accept;
    logic        p;
    logic [24:0] lim;
    logic        last;
    logic [15:0] eid;
    logic [31:0] eval;
    logic [1:0]  es;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    always_comb begin
        phase_next  = phase_reg;
        hcnt_next   = hcnt_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        flags_next  = flags_reg;
        stream_next = stream_reg;
        pcnt_next   = pcnt_reg;
        m6_next     = m6_reg;
        pad_next    = pad_reg;
        coll_next   = coll_reg;
        entry_next  = entry_reg;
        fst_next    = fst_reg;
        ev          = '0;
        ev_push     = 1'b0;
        p    = (type_reg <= FT_HEADERS) && flags_reg[FLAG_PADDED_BIT];
        lim  = (type_reg == FT_HEADERS) ? 25'd5 : 25'd8;
        last = ({1'b0, pcnt_reg} + 25'd1) == {1'b0, len_reg};
        entry_next = {entry_reg[39:0], s_data_byte};
        eid  = entry_next[47:32];
        eval = entry_next[31:0];
        es   = ST_OK;
        if (eid == SET_ENABLE_PUSH && eval > 32'd1) begin
            es = ST_PROTOCOL;
        end else if (eid == SET_INITIAL_WINDOW && eval[31]) begin
            es = ST_PROTOCOL;
        end else if (eid == SET_MAX_FRAME_SIZE && (eval < 32'd16384 || eval[31:24] != 8'd0)) begin
            es = ST_PROTOCOL;
        end
        entry_next = entry_reg;
        if (accept) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (hcnt_reg < 4'd3) begin
                        len_next = {len_reg[15:0], s_data_byte};
                    end else if (hcnt_reg == 4'd3) begin
                        type_next = s_data_byte;
                    end else if (hcnt_reg == 4'd4) begin
                        flags_next = s_data_byte;
                    end else begin
                        stream_next = {stream_reg[22:0], s_data_byte};
                    end
                    if (hcnt_reg != 4'd8) begin
                        hcnt_next = hcnt_reg + 4'd1;
                    end else begin
                        hcnt_next  = '0;
                        pcnt_next  = '0;
                        m6_next    = '0;
                        pad_next   = '0;
                        coll_next  = '0;
                        entry_next = '0;
                        fst_next   = ST_OK;
                        ev.has_sum   = 1'b1;
                        ev.ftype     = type_reg;
                        ev.flags     = flags_reg;
                        ev.stream    = stream_next;
                        ev.length    = len_reg;
                        ev.mod6_zero = 1'b1;
                        if (len_reg > max_reg) begin
                            phase_next  = PH_HALTED;
                            ev.oversize = 1'b1;
                            ev_push     = 1'b1;
                        end else if (len_reg == 24'd0) begin
                            ev_push = 1'b1;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (p && pcnt_reg == 24'd0) begin
                        pad_next = s_data_byte;
                    end
                    if ({1'b0, pcnt_reg} >= {24'd0, p} &&
                        {1'b0, pcnt_reg} < ({24'd0, p} + lim)) begin
                        coll_next = {coll_reg[55:0], s_data_byte};
                    end
                    if (type_reg == FT_SETTINGS) begin
                        entry_next = {entry_reg[39:0], s_data_byte};
                        if (m6_reg == 3'd5 && fst_reg == ST_OK) begin
                            ev.has_entry    = 1'b1;
                            ev.entry_status = es;
                            ev.entry_val    = eval;
                            ev.entry_id     = eid;
                            fst_next        = es;
                        end
                    end
                    m6_next   = (m6_reg == 3'd5) ? 3'd0 : m6_reg + 3'd1;
                    pcnt_next = pcnt_reg + 24'd1;
                    ev.ftype     = type_reg;
                    ev.flags     = flags_reg;
                    ev.stream    = stream_reg;
                    ev.length    = len_reg;
                    ev.pad       = pad_next;
                    ev.coll      = coll_next;
                    ev.fstatus   = fst_next;
                    ev.mod6_zero = (m6_reg == 3'd5);
                    if (last) begin
                        ev.has_sum = 1'b1;
                        phase_next = PH_HEADER;
                    end
                    ev_push = ev.has_entry || last;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            hcnt_reg   <= '0;
            len_reg    <= '0;
            type_reg   <= '0;
            flags_reg  <= '0;
            stream_reg <= '0;
            pcnt_reg   <= '0;
            m6_reg     <= '0;
            pad_reg    <= '0;
            coll_reg   <= '0;
            entry_reg  <= '0;
            fst_reg    <= ST_OK;
            max_reg    <= MAX_FRAME_RESET;
        end else begin
            phase_reg  <= phase_next;
            hcnt_reg   <= hcnt_next;
            len_reg    <= len_next;
            type_reg   <= type_next;
            flags_reg  <= flags_next;
            stream_reg <= stream_next;
            pcnt_reg   <= pcnt_next;
            m6_reg     <= m6_next;
            pad_reg    <= pad_next;
            coll_reg   <= coll_next;
            entry_reg  <= entry_next;
            fst_reg    <= fst_next;
            if (cfg_valid && cfg_ready) begin
                max_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== hdl/h2fp_queue.sv =====
// small event queue between parser and result builder
module h2fp_queue
    import h2fp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  h2fp_event_t push_data,
    input  logic        pop,
    output h2fp_event_t head,
    output logic        empty,
    output logic        full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    h2fp_event_t   mem [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty)) else $error("queue underflow");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

// ===== hdl/h2fp_back.sv =====
// result builder: frame validation and output register
module h2fp_back
    import h2fp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  h2fp_event_t head,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output h2fp_res_t   res
);

    logic        m_valid_reg;
    logic        edone_reg, edone_next;
    h2fp_res_t   res_reg, rec, sum;
    logic        load, emit_entry;
    logic        padded, prio;
    logic [30:0] dep;
    logic        pex;
    logic [31:0] wt;
    logic [2:0]  off;
    logic [24:0] avail;
    logic        padgt;
    logic [23:0] clen;

    always_comb begin
        padded = head.flags[FLAG_PADDED_BIT];
        prio   = head.flags[FLAG_PRIO_BIT];
        dep    = head.coll[38:8];
        pex    = head.coll[39];
        wt     = {23'd0, {1'b0, head.coll[7:0]} + 9'd1};
        off    = 3'(padded);
        if (head.ftype == FT_HEADERS && prio) begin
            off = off + 3'd5;
        end
        avail = {1'b0, head.length} - {22'd0, off};
        padgt = {17'd0, head.pad} > avail;
        clen  = 24'(avail - {17'd0, head.pad});
        sum        = '0;
        sum.kind   = KIND_SUMMARY;
        sum.ftype  = head.ftype;
        sum.flags  = head.flags;
        sum.stream = head.stream;
        sum.length = head.length;
        sum.last   = 1'b1;
        case (head.ftype)
            FT_DATA: begin
                sum.offset = off;
                if (head.stream == '0) sum.status = ST_PROTOCOL;
                else if (padded && head.length == '0) sum.status = ST_PROTOCOL;
                else if (padgt) sum.status = ST_PROTOCOL;
                else sum.clen = clen;
            end
            FT_HEADERS: begin
                sum.offset = off;
                if (head.stream == '0) sum.status = ST_PROTOCOL;
                else if (padded && head.length == '0) sum.status = ST_PROTOCOL;
                else if (prio && head.length < {21'd0, off}) sum.status = ST_FRAME_SIZE;
                else if (padgt) sum.status = ST_PROTOCOL;
                else if (prio && dep == head.stream) sum.status = ST_PROTOCOL;
                else begin
                    sum.clen = clen;
                    if (prio) begin
                        sum.v1   = {33'd0, dep};
                        sum.v2   = wt;
                        sum.excl = pex;
                    end else begin
                        sum.v2 = 32'd16;
                    end
                end
            end
            FT_PRIORITY: begin
                if (head.stream == '0) sum.status = ST_PROTOCOL;
                else if (head.length != 24'd5) sum.status = ST_FRAME_SIZE;
                else if (dep == head.stream) sum.status = ST_PROTOCOL;
                else begin
                    sum.v1   = {33'd0, dep};
                    sum.v2   = wt;
                    sum.excl = pex;
                end
            end
            FT_RST_STREAM: begin
                if (head.stream == '0) sum.status = ST_PROTOCOL;
                else if (head.length != 24'd4) sum.status = ST_FRAME_SIZE;
                else sum.v1 = {32'd0, head.coll[31:0]};
            end
            FT_SETTINGS: begin
                if (head.fstatus != ST_OK) sum.status = head.fstatus;
                else if (!head.mod6_zero) sum.status = ST_FRAME_SIZE;
            end
            FT_PING: begin
                if (head.stream != '0) sum.status = ST_PROTOCOL;
                else if (head.length != 24'd8) sum.status = ST_FRAME_SIZE;
                else sum.v1 = head.coll;
            end
            FT_GOAWAY: begin
                if (head.stream != '0) sum.status = ST_PROTOCOL;
                else if (head.length < 24'd8) sum.status = ST_FRAME_SIZE;
                else begin
                    sum.v1 = {33'd0, head.coll[62:32]};
                    sum.v2 = head.coll[31:0];
                end
            end
            FT_WINDOW_UPDATE: begin
                if (head.length != 24'd4) sum.status = ST_FRAME_SIZE;
                else if (head.coll[30:0] == '0) sum.status = ST_PROTOCOL;
                else sum.v1 = {33'd0, head.coll[30:0]};
            end
            FT_CONTINUATION: begin
                if (head.stream == '0) sum.status = ST_PROTOCOL;
                else sum.clen = head.length;
            end
            default: begin
            end
        endcase
        if (head.oversize) begin
            sum.status = ST_FRAME_SIZE;
        end
        if (sum.status != ST_OK) begin
            sum.offset = '0;
            sum.clen   = '0;
            sum.v1     = '0;
            sum.v2     = '0;
            sum.excl   = 1'b0;
        end
    end

    assign emit_entry = head.has_entry && !edone_reg;
    assign load       = !q_empty && (!m_valid_reg || m_ready);
    assign pop        = load && !(emit_entry && head.has_sum);

    always_comb begin
        rec = sum;
        if (emit_entry) begin
            rec        = '0;
            rec.kind   = KIND_ENTRY;
            rec.ftype  = head.ftype;
            rec.flags  = head.flags;
            rec.stream = head.stream;
            rec.length = head.length;
            rec.status = head.entry_status;
            rec.v1     = {32'd0, head.entry_val};
            rec.v2     = {16'd0, head.entry_id};
            rec.last   = !head.has_sum;
        end
        edone_next = edone_reg;
        if (load) begin
            edone_next = emit_entry && head.has_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            edone_reg   <= 1'b0;
        end else begin
            edone_reg <= edone_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign res     = res_reg;

    a_entry_then_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        edone_reg |-> (!q_empty && head.has_sum)) else $error("lost summary after entry");
    a_pop_ends_event: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> rec.last) else $error("event popped before its last result");
    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.kind == KIND_SUMMARY) |-> res_reg.last)
        else $error("summary not marked last");

endmodule

// ===== hdl/h2_frame_parser_validator.sv =====
// top level of the http/2 frame parser and validator
//
//  channel  dir  handshake             payload
//  s_       in   s_valid / s_ready     s_data_byte
//  m_       out  m_valid / m_ready     m_result_kind .. m_last_of_run
//  cfg_     in   cfg_valid / cfg_ready cfg_data (max frame bytes)
//
// one byte per cycle in while s_ready is high; a byte ending a settings entry
// on the last payload byte yields two results for the output stage to drain
// the event queue absorbs those; s_ready drops only when the queue is full
// reset restores max frame bytes to 16384; an oversized frame halts until reset
module h2_frame_parser_validator
    import h2fp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_frame_type,
    output logic [7:0]  m_frame_flags,
    output logic [30:0] m_stream_ident,
    output logic [23:0] m_frame_length,
    output logic [1:0]  m_status,
    output logic [2:0]  m_content_offset,
    output logic [23:0] m_content_length,
    output logic [63:0] m_value_primary,
    output logic [31:0] m_value_secondary,
    output logic        m_exclusive_flag,
    output logic        m_last_of_run
);

    h2fp_event_t ev, head;
    h2fp_res_t   res;
    logic        ev_push, pop, q_empty, q_full;

    h2fp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .ev_push     (ev_push),
        .ev          (ev)
    );

    h2fp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (ev_push),
        .push_data (ev),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    h2fp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .res     (res)
    );

    assign m_result_kind     = res.kind;
    assign m_frame_type      = res.ftype;
    assign m_frame_flags     = res.flags;
    assign m_stream_ident    = res.stream;
    assign m_frame_length    = res.length;
    assign m_status          = res.status;
    assign m_content_offset  = res.offset;
    assign m_content_length  = res.clen;
    assign m_value_primary   = res.v1;
    assign m_value_secondary = res.v2;
    assign m_exclusive_flag  = res.excl;
    assign m_last_of_run     = res.last;

endmodule
